// ===== hdl/lzw_compressor_core_macros.svh =====
// Assertion macros for the LZW compressor RTL.
`ifndef LZW_COMPRESSOR_CORE_MACROS_SVH
`define LZW_COMPRESSOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define LZWC_CHECK_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define LZWC_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/lzwc_pkg.sv =====
// Shared constants, types and helper functions of the LZW compressor.
`default_nettype none

package lzwc_pkg;

    localparam int DATA_W         = 8;
    localparam int CODE_W         = 12;
    localparam int WIDTH_W        = 4;
    localparam int KEY_W          = CODE_W + DATA_W;
    localparam int NEXT_W         = 13;
    localparam int ALPHABET       = 256;
    localparam int CODE_CEIL      = 4095;
    localparam int MAX_CODE_DEF   = 4095;
    localparam int HASH_SLOTS_DEF = 8192;
    localparam int MAX_RESULTS    = 4;
    localparam int OUT_DEPTH      = 4;
    localparam int COUNT_W        = 5;

    localparam logic [15:0]          HASH_MUL       = 16'd40503;
    localparam logic [NEXT_W-1:0]    FIRST_CODE     = NEXT_W'(ALPHABET + 1);
    localparam logic [WIDTH_W-1:0]   INIT_WIDTH_RST = 4'd9;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [CODE_W-1:0] code;
    } dict_entry_t;

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [WIDTH_W-1:0] width;
        logic               escape;
        logic               eos;
    } result_t;

    // Number of bits needed to write a code (zero needs none).
    function automatic logic [WIDTH_W-1:0] bit_len(input logic [CODE_W-1:0] value);
        logic [WIDTH_W-1:0] len;
        len = '0;
        for (int i = 0; i < CODE_W; i++)
        begin
            if (value[i])
            begin
                len = WIDTH_W'(i + 1);
            end
        end
        return len;
    endfunction

    // A programmed width of zero starts the stream at one bit.
    function automatic logic [WIDTH_W-1:0] start_width(input logic [WIDTH_W-1:0] w);
        return (w == '0) ? WIDTH_W'(1) : w;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/lzw_compressor_core.sv =====
// Top level of the LZW compressor with variable code width and escape codes.
//
// Input stream: one byte per word on s_axis (tdata = byte, tlast marks the
// final byte of a stream). Output stream: one code per word on m_axis, with
// tuser set on a width-increase escape (code zero) and tlast on the final
// code of a stream. cfg_we/cfg_wdata load the starting code width.
// Each byte after the first of a stream is hashed and then looked up in the
// dictionary by linear probing; each probe is one read of the single dictionary
// memory followed by a compare, and a filled slot that does not match moves the
// probe on to the next slot. A byte that produces codes then counts them and
// steps through each code or dropped result into a four-word output queue.
// After reset, and again after the final code of each stream, the dictionary
// is wiped one entry per cycle, with s_axis_tready low.
// While m_axis is stalled, codes wait in the queue; the block keeps taking
// bytes until the queue is full, then holds the sequencer.
`default_nettype none

`include "lzw_compressor_core_macros.svh"

module lzw_compressor_core #(
    parameter int MAX_CODE   = lzwc_pkg::MAX_CODE_DEF,
    parameter int HASH_SLOTS = lzwc_pkg::HASH_SLOTS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [11:0] code, [15:12] code_width
    output logic             m_axis_tuser,   // [0] is_escape
    output logic             m_axis_tlast,
    input  wire logic        cfg_we,
    input  wire logic [3:0]  cfg_wdata
);

    localparam int SLOT_W  = $clog2(HASH_SLOTS);
    localparam int EFF_MAX = (MAX_CODE < lzwc_pkg::CODE_CEIL) ? MAX_CODE
                                                               : lzwc_pkg::CODE_CEIL;

    logic [lzwc_pkg::WIDTH_W-1:0] init_width_reg;
    logic [lzwc_pkg::WIDTH_W-1:0] init_width_next;

    logic                  ram_wr_en;
    logic [SLOT_W-1:0]     ram_wr_addr;
    lzwc_pkg::dict_entry_t ram_wr_data;
    logic                  ram_rd_en;
    logic [SLOT_W-1:0]     ram_rd_addr;
    lzwc_pkg::dict_entry_t ram_rd_data;
    logic                  res_valid;
    lzwc_pkg::result_t     res_word;
    logic                  res_full;
    lzwc_pkg::result_t     head;

    assign init_width_next = cfg_we ? cfg_wdata : init_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_width_reg <= lzwc_pkg::INIT_WIDTH_RST;
        end
        else
        begin
            init_width_reg <= init_width_next;
        end
    end

    lzwc_dict_ram #(
        .DEPTH (HASH_SLOTS)
    ) u_dict (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    lzwc_ctrl #(
        .MAX_CODE   (MAX_CODE),
        .HASH_SLOTS (HASH_SLOTS)
    ) u_ctrl (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (s_axis_tvalid),
        .in_ready           (s_axis_tready),
        .in_byte            (s_axis_tdata),
        .in_last            (s_axis_tlast),
        .cfg_load           (cfg_we),
        .cfg_start_width    (lzwc_pkg::start_width(cfg_wdata)),
        .stream_start_width (lzwc_pkg::start_width(init_width_reg)),
        .ram_wr_en          (ram_wr_en),
        .ram_wr_addr        (ram_wr_addr),
        .ram_wr_data        (ram_wr_data),
        .ram_rd_en          (ram_rd_en),
        .ram_rd_addr        (ram_rd_addr),
        .ram_rd_data        (ram_rd_data),
        .res_valid          (res_valid),
        .res_word           (res_word),
        .res_full           (res_full)
    );

    lzwc_out_fifo u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (res_valid),
        .push_data  (res_word),
        .full       (res_full),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (head)
    );

    assign m_axis_tdata = {head.width, head.code};
    assign m_axis_tuser = head.escape;
    assign m_axis_tlast = head.eos;

    `LZWC_CHECK_NEXT(a_eos_starts_wipe, res_valid && !res_full && res_word.eos, !s_axis_tready, "byte accepted right after the final code of a stream")
    `LZWC_CHECK_IMPL(a_wipe_blocks_input, ram_wr_en && !ram_wr_data.valid, !s_axis_tready, "byte accepted while the dictionary is being wiped")
    `LZWC_CHECK_IMPL(a_insert_code_range, ram_wr_en && ram_wr_data.valid, (ram_wr_data.code >= 12'(lzwc_pkg::ALPHABET + 1)) && (ram_wr_data.code <= 12'(EFF_MAX)), "dictionary insert with a code outside the assignable range")
    `LZWC_CHECK_IMPL(a_escape_not_final, m_axis_tvalid && m_axis_tuser, (m_axis_tdata[11:0] == 12'd0) && !m_axis_tlast, "escape word with a nonzero code or marked as final")

endmodule

`default_nettype wire

// ===== hdl/lzwc_dict_ram.sv =====
// Dictionary memory: one write port and one registered read port.
`default_nettype none

module lzwc_dict_ram #(
    parameter int DEPTH = lzwc_pkg::HASH_SLOTS_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                  clk,
    input  wire logic                  wr_en,
    input  wire logic [ADDR_W-1:0]     wr_addr,
    input  wire lzwc_pkg::dict_entry_t wr_data,
    input  wire logic                  rd_en,
    input  wire logic [ADDR_W-1:0]     rd_addr,
    output lzwc_pkg::dict_entry_t      rd_data
);

    lzwc_pkg::dict_entry_t mem [DEPTH];
    lzwc_pkg::dict_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hdl/lzwc_out_fifo.sv =====
// Small result queue that decouples the code sequencer from the output stream.
`default_nettype none

module lzwc_out_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    input  wire lzwc_pkg::result_t push_data,
    output logic                   full,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output lzwc_pkg::result_t      out_data
);

    localparam int PTR_W = $clog2(lzwc_pkg::OUT_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    lzwc_pkg::result_t entries [lzwc_pkg::OUT_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(lzwc_pkg::OUT_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = entries[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lzwc_ctrl.sv =====
// Sequencer: dictionary lookup with linear probing, insert, and code emission.
`default_nettype none

module lzwc_ctrl #(
    parameter int MAX_CODE   = lzwc_pkg::MAX_CODE_DEF,
    parameter int HASH_SLOTS = lzwc_pkg::HASH_SLOTS_DEF,
    localparam int SLOT_W    = $clog2(HASH_SLOTS)
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [lzwc_pkg::DATA_W-1:0]       in_byte,
    input  wire logic                              in_last,
    input  wire logic                              cfg_load,
    input  wire logic [lzwc_pkg::WIDTH_W-1:0]      cfg_start_width,
    input  wire logic [lzwc_pkg::WIDTH_W-1:0]      stream_start_width,
    output logic                                   ram_wr_en,
    output logic [SLOT_W-1:0]                      ram_wr_addr,
    output lzwc_pkg::dict_entry_t                  ram_wr_data,
    output logic                                   ram_rd_en,
    output logic [SLOT_W-1:0]                      ram_rd_addr,
    input  wire lzwc_pkg::dict_entry_t             ram_rd_data,
    output logic                                   res_valid,
    output lzwc_pkg::result_t                      res_word,
    input  wire logic                              res_full
);

    localparam int CODE_W  = lzwc_pkg::CODE_W;
    localparam int WIDTH_W = lzwc_pkg::WIDTH_W;
    localparam int KEY_W   = lzwc_pkg::KEY_W;
    localparam int NEXT_W  = lzwc_pkg::NEXT_W;
    localparam int COUNT_W = lzwc_pkg::COUNT_W;
    localparam int EFF_MAX = (MAX_CODE < lzwc_pkg::CODE_CEIL) ? MAX_CODE
                                                               : lzwc_pkg::CODE_CEIL;
    localparam int PROD_W  = KEY_W + 16;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_CHECK,
        S_COUNT,
        S_EMIT
    } state_t;

    state_t              state_reg,  state_next;
    logic [CODE_W-1:0]   prefix_reg, prefix_next;
    logic                have_reg,   have_next;
    logic [NEXT_W-1:0]   ncode_reg,  ncode_next;
    logic [WIDTH_W-1:0]  cw_reg,     cw_next;
    logic [KEY_W-1:0]    key_reg,    key_next;
    logic                last_reg,   last_next;
    logic [SLOT_W-1:0]   idx_reg,    idx_next;
    logic [SLOT_W-1:0]   probe_reg,  probe_next;
    logic [SLOT_W-1:0]   clr_reg,    clr_next;
    logic [CODE_W-1:0]   c1_reg,     c1_next;
    logic                send1_reg,  send1_next;
    logic                phase_reg,  phase_next;
    logic [COUNT_W-1:0]  skip_reg,   skip_next;

    logic [PROD_W-1:0]   hash_prod;
    logic [CODE_W-1:0]   in_literal;
    logic [CODE_W-1:0]   key_literal;
    logic                hit;
    logic [WIDTH_W-1:0]  bl1;
    logic [WIDTH_W-1:0]  bl2;
    logic [WIDTH_W-1:0]  esc1;
    logic [WIDTH_W-1:0]  esc2;
    logic [WIDTH_W-1:0]  cw_mid;
    logic [COUNT_W-1:0]  total;
    logic [CODE_W-1:0]   cur_code;
    logic [WIDTH_W-1:0]  cur_len;
    logic                cur_esc;

    assign in_ready    = (state_reg == S_IDLE);
    assign ram_rd_addr = idx_reg;
    assign in_literal  = CODE_W'(in_byte) + CODE_W'(1);
    assign key_literal = CODE_W'(key_reg[lzwc_pkg::DATA_W-1:0]) + CODE_W'(1);
    assign hash_prod   = PROD_W'(key_reg) * PROD_W'(lzwc_pkg::HASH_MUL);
    assign hit         = ram_rd_data.valid && (ram_rd_data.key == key_reg);

    // Result count of one byte; the earliest results beyond the limit are dropped.
    always_comb
    begin
        bl1    = lzwc_pkg::bit_len(c1_reg);
        bl2    = lzwc_pkg::bit_len(prefix_reg);
        esc1   = (send1_reg && (bl1 > cw_reg)) ? WIDTH_W'(bl1 - cw_reg) : '0;
        cw_mid = (send1_reg && (bl1 > cw_reg)) ? bl1 : cw_reg;
        esc2   = (last_reg && (bl2 > cw_mid)) ? WIDTH_W'(bl2 - cw_mid) : '0;
        total  = (send1_reg ? COUNT_W'(COUNT_W'(esc1) + 1'b1) : '0)
               + (last_reg ? COUNT_W'(COUNT_W'(esc2) + 1'b1) : '0);
    end

    assign cur_code = phase_reg ? prefix_reg : c1_reg;
    assign cur_len  = lzwc_pkg::bit_len(cur_code);
    assign cur_esc  = (cw_reg < cur_len);

    always_comb
    begin
        state_next  = state_reg;
        prefix_next = prefix_reg;
        have_next   = have_reg;
        ncode_next  = ncode_reg;
        cw_next     = cw_reg;
        key_next    = key_reg;
        last_next   = last_reg;
        idx_next    = idx_reg;
        probe_next  = probe_reg;
        clr_next    = clr_reg;
        c1_next     = c1_reg;
        send1_next  = send1_reg;
        phase_next  = phase_reg;
        skip_next   = skip_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = idx_reg;
        ram_wr_data = '0;
        ram_rd_en   = 1'b0;
        res_valid   = 1'b0;
        res_word    = '0;

        case (state_reg)
            S_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_reg;
                clr_next    = SLOT_W'(clr_reg + 1'b1);
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    key_next  = {prefix_reg, in_byte};
                    last_next = in_last;
                    if (!have_reg)
                    begin
                        prefix_next = in_literal;
                        have_next   = 1'b1;
                        send1_next  = 1'b0;
                        state_next  = in_last ? S_COUNT : S_IDLE;
                    end
                    else
                    begin
                        state_next = S_HASH;
                    end
                end
            end

            S_HASH:
            begin
                idx_next   = hash_prod[SLOT_W-1:0];
                probe_next = '0;
                state_next = S_PROBE;
            end

            S_PROBE:
            begin
                ram_rd_en  = 1'b1;
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                if (hit)
                begin
                    prefix_next = ram_rd_data.code;
                    send1_next  = 1'b0;
                    state_next  = last_reg ? S_COUNT : S_IDLE;
                end
                else if (ram_rd_data.valid && (probe_reg != '1))
                begin
                    idx_next   = SLOT_W'(idx_reg + 1'b1);
                    probe_next = SLOT_W'(probe_reg + 1'b1);
                    state_next = S_PROBE;
                end
                else
                begin
                    // Miss: emit the old prefix; insert only into a free slot.
                    send1_next  = 1'b1;
                    c1_next     = prefix_reg;
                    prefix_next = key_literal;
                    if (!ram_rd_data.valid && (ncode_reg <= NEXT_W'(EFF_MAX)))
                    begin
                        ram_wr_en         = 1'b1;
                        ram_wr_data.valid = 1'b1;
                        ram_wr_data.key   = key_reg;
                        ram_wr_data.code  = ncode_reg[CODE_W-1:0];
                        ncode_next        = NEXT_W'(ncode_reg + 1'b1);
                    end
                    state_next = S_COUNT;
                end
            end

            S_COUNT:
            begin
                skip_next  = (total > COUNT_W'(lzwc_pkg::MAX_RESULTS))
                           ? COUNT_W'(total - COUNT_W'(lzwc_pkg::MAX_RESULTS)) : '0;
                phase_next = !send1_reg;
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                res_word.code   = cur_esc ? '0 : cur_code;
                res_word.width  = cw_reg;
                res_word.escape = cur_esc;
                res_word.eos    = last_reg && phase_reg && !cur_esc;
                if (skip_reg != '0)
                begin
                    skip_next = COUNT_W'(skip_reg - 1'b1);
                end
                else
                begin
                    res_valid = 1'b1;
                end
                if ((skip_reg != '0) || !res_full)
                begin
                    if (cur_esc)
                    begin
                        cw_next = WIDTH_W'(cw_reg + 1'b1);
                    end
                    else if (!phase_reg && last_reg)
                    begin
                        phase_next = 1'b1;
                    end
                    else if (last_reg)
                    begin
                        prefix_next = '0;
                        have_next   = 1'b0;
                        ncode_next  = lzwc_pkg::FIRST_CODE;
                        cw_next     = stream_start_width;
                        clr_next    = '0;
                        state_next  = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_load)
        begin
            cw_next = cfg_start_width;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            prefix_reg <= '0;
            have_reg   <= 1'b0;
            ncode_reg  <= lzwc_pkg::FIRST_CODE;
            cw_reg     <= lzwc_pkg::INIT_WIDTH_RST;
            last_reg   <= 1'b0;
            probe_reg  <= '0;
            clr_reg    <= '0;
            send1_reg  <= 1'b0;
            phase_reg  <= 1'b0;
            skip_reg   <= '0;
            key_reg    <= '0;
            idx_reg    <= '0;
            c1_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            prefix_reg <= prefix_next;
            have_reg   <= have_next;
            ncode_reg  <= ncode_next;
            cw_reg     <= cw_next;
            last_reg   <= last_next;
            probe_reg  <= probe_next;
            clr_reg    <= clr_next;
            send1_reg  <= send1_next;
            phase_reg  <= phase_next;
            skip_reg   <= skip_next;
            key_reg    <= key_next;
            idx_reg    <= idx_next;
            c1_reg     <= c1_next;
        end
    end

endmodule

`default_nettype wire

// ===== tb/lzw_compressor_core_test.sv =====
// Self-checking testbench of the LZW compressor core with a scoreboard that predicts every code.
module lzw_compressor_core_test;
    import lzwc_pkg::*;

    localparam int CYCLE_LIMIT   = 4000000;
    localparam int LAST_NEW_CODE = (MAX_CODE_DEF < CODE_CEIL) ? MAX_CODE_DEF : CODE_CEIL;
    localparam int WIDTH_CEIL    = 15;
    localparam int SETTLE_CYCLES = 64;
    localparam int IDLE_PCT      = 29;
    localparam int FILL_LEN      = 30;
    localparam int PHASE_BYTES   = 45;

    class lzw_scoreboard;
        logic [WIDTH_W-1:0] start_bits;
        logic [CODE_W-1:0]  prefix;
        bit                 prefix_valid;
        int                 next_free;
        int                 width_now;
        int                 dict[int];
        result_t            awaited[$];
        result_t            step_codes[$];
        int                 errors;

        function new();
            start_bits = INIT_WIDTH_RST;
            errors     = 0;
            restart();
        endfunction

        function int first_width();
            return (start_bits == '0) ? 1 : int'(start_bits);
        endfunction

        function void restart();
            prefix       = '0;
            prefix_valid = 1'b0;
            next_free    = ALPHABET + 1;
            width_now    = first_width();
            dict.delete();
        endfunction

        function void load_width(logic [WIDTH_W-1:0] w);
            start_bits = w;
            width_now  = first_width();
        endfunction

        // Escape zeros widen the code one bit at a time until the value fits.
        function void emit(int value);
            result_t r;
            while (width_now < WIDTH_CEIL && (1 << width_now) <= value)
            begin
                r = {CODE_W'(0), WIDTH_W'(width_now), 1'b1, 1'b0};
                step_codes.push_back(r);
                width_now++;
            end
            r = {CODE_W'(value), WIDTH_W'(width_now), 1'b0, 1'b0};
            step_codes.push_back(r);
        endfunction

        function void note_byte(logic [DATA_W-1:0] b, logic last);
            int      key;
            result_t r;
            step_codes.delete();
            if (!prefix_valid)
            begin
                prefix       = {4'd0, b} + 12'd1;
                prefix_valid = 1'b1;
            end
            else
            begin
                key = int'({prefix, b});
                if (dict.exists(key))
                begin
                    prefix = CODE_W'(dict[key]);
                end
                else
                begin
                    emit(int'(prefix));
                    // The hashed table always has a free slot, since it is larger than the
                    // code space; only the code bound stops new entries.
                    if (next_free <= LAST_NEW_CODE)
                    begin
                        dict[key] = next_free;
                        next_free++;
                    end
                    prefix = {4'd0, b} + 12'd1;
                end
            end
            if (last)
            begin
                emit(int'(prefix));
                r     = step_codes.pop_back();
                r.eos = 1'b1;
                step_codes.push_back(r);
            end
            // Only the last four codes of one byte come out; the earliest ones are dropped.
            while (step_codes.size() > MAX_RESULTS)
            begin
                void'(step_codes.pop_front());
            end
            foreach (step_codes[i])
            begin
                awaited.push_back(step_codes[i]);
            end
            if (last)
            begin
                restart();
            end
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_code(result_t got);
            result_t want;
            if (awaited.size() == 0)
            begin
                report($sformatf("unexpected word code=%0d width=%0d esc=%0b last=%0b",
                                 got.code, got.width, got.escape, got.eos));
                return;
            end
            want = awaited.pop_front();
            if (got.code !== want.code || got.width !== want.width ||
                got.escape !== want.escape || got.eos !== want.eos)
            begin
                report($sformatf("code=%0d/%0d width=%0d/%0d esc=%0b/%0b last=%0b/%0b (got/exp)",
                                 got.code, want.code, got.width, want.width,
                                 got.escape, want.escape, got.eos, want.eos));
            end
        endtask
    endclass

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata  = '0;
    logic               s_axis_tlast  = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [15:0]        m_axis_tdata;
    logic               m_axis_tuser;
    logic               m_axis_tlast;
    logic               cfg_we        = 1'b0;
    logic [3:0]         cfg_wdata     = '0;
    logic               steady        = 1'b0;
    int                 cycle_count   = 0;
    result_t            seen;
    lzw_scoreboard      sb            = new();

    lzw_compressor_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen = {m_axis_tdata[11:0], m_axis_tdata[15:12], m_axis_tuser, m_axis_tlast};
                sb.check_code(seen);
            end
            m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Leaves tvalid high after the accepting edge so back-to-back words need no toggle.
    task automatic send_byte(input logic [7:0] value, input logic last);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        sb.note_byte(value, last);
    endtask

    task automatic drain_codes();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_width(input logic [3:0] w);
        drain_codes();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.load_width(w);
    endtask

    // A narrow alphabet makes repeats common, so the dictionary gets hit and chains grow.
    task automatic send_stream(input int len, input bit narrow, input int hold_at);
        logic [7:0] sym [4];
        int         n_sym;
        logic [7:0] value;
        n_sym = $urandom_range(4, 1);
        foreach (sym[i])
        begin
            sym[i] = 8'($urandom_range(255));
        end
        for (int i = 0; i < len; i++)
        begin
            if (i == hold_at)
            begin
                drain_codes();
            end
            value = narrow ? sym[$urandom_range(n_sym - 1)] : 8'($urandom_range(255));
            send_byte(value, i == len - 1);
        end
    endtask

    initial
    begin
        logic [3:0] widths [6];
        int         sent;
        int         len;
        widths = '{4'd1, 4'd12, 4'd5, 4'd0, 4'd9, 4'd0};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset width: repeats, a one-byte stream, both byte extremes.
        send_byte(8'd0, 1'b0);
        send_byte(8'd0, 1'b0);
        send_byte(8'd0, 1'b0);
        send_byte(8'd0, 1'b0);
        send_byte(8'd255, 1'b1);
        send_byte(8'd255, 1'b1);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b1);
        // One bit wide: literal 256 needs eight escapes, so the earliest ones are dropped.
        write_width(4'd1);
        send_byte(8'd255, 1'b0);
        send_byte(8'd0, 1'b1);
        write_width(4'd0);
        send_byte(8'd0, 1'b1);
        send_byte(8'd7, 1'b0);
        send_byte(8'd7, 1'b0);
        send_byte(8'd7, 1'b0);
        send_byte(8'd7, 1'b1);
        write_width(4'd12);
        send_byte(8'd128, 1'b0);
        send_byte(8'd128, 1'b0);
        send_byte(8'd255, 1'b1);

        for (int p = 0; p < 6; p++)
        begin
            write_width(p == 5 ? 4'($urandom_range(12, 1)) : widths[p]);
            steady <= (p == 2);
            sent = 0;
            while (sent < PHASE_BYTES)
            begin
                len = ($urandom_range(9) == 0) ? 1 : $urandom_range(40, 2);
                if (p == 1 && sent == 0)
                begin
                    // Hold the sender mid-stream until all codes so far have come out.
                    len = 20;
                    send_stream(len, 1'b1, len / 2);
                end
                else
                begin
                    send_stream(len, $urandom_range(9) < 7, -1);
                end
                sent += len;
            end
        end

        // A stream of random bytes from a narrow start width forces many escapes.
        write_width(4'd3);
        steady <= 1'b0;
        send_stream(FILL_LEN, 1'b0, -1);
        write_width(4'd9);
        send_stream(20, 1'b1, -1);

        drain_codes();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/lzwc_pkg.sv
hdl/lzwc_dict_ram.sv
hdl/lzwc_out_fifo.sv
hdl/lzwc_ctrl.sv
hdl/lzw_compressor_core.sv
tb/lzw_compressor_core_test.sv
